[hw/rtl/csr_pkg.sv]
package csr_pkg;

  localparam int WORD_W    = 64;
  localparam int TABLE_DIM = 65;
  localparam int IDX_W     = $clog2(TABLE_DIM);
  localparam int ADDR_W    = $clog2(TABLE_DIM * TABLE_DIM);
  localparam int TABLE_N   = TABLE_DIM * TABLE_DIM;
  localparam int SHIFT_W   = $clog2(WORD_W);

  localparam int SECTOR_W  = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BITS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SECTORS = 1'd1;

  typedef struct packed {
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] k;
  } lookup_t;

endpackage

[hw/rtl/csr_if.sv]
interface csr_in_if;
  import csr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] spin_word;
  logic              first_of_batch;

  modport source (output valid, output spin_word, output first_of_batch, input ready);
  modport sink   (input valid, input spin_word, input first_of_batch, output ready);
endinterface

interface csr_out_if;
  import csr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] state_index;

  modport source (output valid, output state_index, input ready);
  modport sink   (input valid, input state_index, output ready);
endinterface

[hw/rtl/csr_binom_table.sv]
module csr_binom_table
  import csr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lookup_t           lookup,
  output logic [WORD_W-1:0] rdata,
  output logic              fill_done
);

  typedef enum logic [2:0] {
    F_READ  = 3'b001,
    F_WRITE = 3'b010,
    F_READY = 3'b100
  } fill_state_t;

  logic [WORD_W-1:0] mem [0:TABLE_N-1];
  logic [WORD_W-1:0] mem_q;
  logic              k_over_n;

  fill_state_t       state;
  fill_state_t       state_next;
  logic [IDX_W-1:0]  fill_n;
  logic [IDX_W-1:0]  fill_k;
  logic [WORD_W-1:0] held;
  logic [WORD_W-1:0] fill_val;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic              advance;
  logic              row_end;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [IDX_W-1:0] n,
                                                input logic [IDX_W-1:0] k);
    tbl_addr = ADDR_W'(n) * ADDR_W'(TABLE_DIM) + ADDR_W'(k);
  endfunction

  assign row_end  = (fill_k == fill_n);
  assign fill_val = row_end ? '0 : mem_q;

  always_comb begin
    we         = 1'b0;
    waddr      = tbl_addr(fill_n, fill_k);
    wdata      = '0;
    raddr      = tbl_addr(lookup.n, lookup.k);
    advance    = 1'b0;
    state_next = state;
    unique case (state)
      F_READ: begin
        if (fill_k == '0) begin
          we      = 1'b1;
          wdata   = WORD_W'(1);
          advance = 1'b1;
        end else begin
          raddr      = tbl_addr(IDX_W'(fill_n - IDX_W'(1)), fill_k);
          state_next = F_WRITE;
        end
      end
      F_WRITE: begin
        we         = 1'b1;
        wdata      = held + fill_val;
        advance    = 1'b1;
        state_next = F_READ;
      end
      F_READY: begin
      end
      default: begin
        state_next = F_READY;
      end
    endcase
    if (advance && row_end && (fill_n == IDX_W'(TABLE_DIM - 1))) begin
      state_next = F_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_READ;
      fill_n <= '0;
      fill_k <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        if (row_end) begin
          fill_n <= IDX_W'(fill_n + IDX_W'(1));
          fill_k <= '0;
        end else begin
          fill_k <= IDX_W'(fill_k + IDX_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_READ && fill_k == '0) begin
      held <= WORD_W'(1);
    end else if (state == F_WRITE) begin
      held <= fill_val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q    <= mem[raddr];
    k_over_n <= (lookup.k > lookup.n);
  end

  assign rdata     = k_over_n ? '0 : mem_q;
  assign fill_done = (state == F_READY);

endmodule

[hw/rtl/combinadic_state_rank_unit.sv]
// Ranks one 64-bit occupation word per transfer in the combinatorial number
// system, optionally splitting it into a low and a high sector. After reset the
// binomial memory is built row by row; no word is accepted until it is
// complete, although configuration writes are taken. An item then scans every
// bit position of the word in turn, looking each up through the single read
// port of the binomial memory, settles the last sum in S_DRAIN and loads the
// output register in S_DONE, where it waits while an earlier result is still
// untaken. A word with first_of_batch set adds S_LATCH for the sector count
// lookup, and split-sector mode adds S_MUL0, S_MUL1 and S_MUL2 for the 64-bit
// product. The unit then returns to S_IDLE before it takes the next word. A
// new word is accepted while the last result still waits in the output
// register.
module combinadic_state_rank_unit
  import csr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  csr_in_if.sink               word_ch,
  csr_out_if.source            rank_ch
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_LATCH = 8'b0000_1000,
    S_MUL0  = 8'b0001_0000,
    S_MUL1  = 8'b0010_0000,
    S_MUL2  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t              state;
  state_t              state_next;

  logic [SECTOR_W-1:0] sector_bits;
  logic                split_sectors;
  logic [IDX_W-1:0]    nb;

  logic [WORD_W-1:0]   word_sh;
  logic                first;
  logic [SHIFT_W-1:0]  bit_pos;
  logic [IDX_W-1:0]    cnt_low;
  logic [IDX_W-1:0]    cnt_high;
  logic [IDX_W-1:0]    cnt_all;
  logic [WORD_W-1:0]   acc_low;
  logic [WORD_W-1:0]   acc_high;
  logic [WORD_W-1:0]   low_sector_count;
  logic                pend;
  logic                pend_high;

  logic                is_low;
  logic                hi_sel;
  logic                bit_set;
  lookup_t             lookup;
  logic [WORD_W-1:0]   rdata;
  logic                fill_done;

  logic [WORD_W/2-1:0] mul_a;
  logic [WORD_W/2-1:0] mul_b;
  logic [WORD_W-1:0]   mul_full;
  logic [WORD_W-1:0]   prod;

  logic                accept;
  logic                load;
  logic [WORD_W-1:0]   out_data;
  logic                out_valid;

  csr_binom_table u_table (
    .clk       (clk),
    .rst       (rst),
    .lookup    (lookup),
    .rdata     (rdata),
    .fill_done (fill_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_bits   <= SECTOR_W'(WORD_W);
      split_sectors <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECTOR_BITS:   sector_bits   <= cfg_data[SECTOR_W-1:0];
        REG_SPLIT_SECTORS: split_sectors <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign nb = (sector_bits >= SECTOR_W'(WORD_W)) ? IDX_W'(WORD_W) : IDX_W'(sector_bits);

  assign is_low  = (IDX_W'(bit_pos) < nb);
  assign hi_sel  = split_sectors & ~is_low;
  assign bit_set = word_sh[0];

  always_comb begin
    lookup.n = IDX_W'(bit_pos);
    lookup.k = IDX_W'(cnt_all + IDX_W'(1));
    if (state == S_DRAIN) begin
      lookup.n = nb;
      lookup.k = cnt_low;
    end else if (hi_sel) begin
      lookup.n = IDX_W'(IDX_W'(bit_pos) - nb);
      lookup.k = IDX_W'(cnt_high + IDX_W'(1));
    end else if (split_sectors) begin
      lookup.k = IDX_W'(cnt_low + IDX_W'(1));
    end
  end

  assign accept = word_ch.valid & word_ch.ready;
  assign load   = (state == S_DONE) & (~out_valid | rank_ch.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (bit_pos == SHIFT_W'(WORD_W - 1)) state_next = S_DRAIN;
      S_DRAIN: begin
        if (first) begin
          state_next = S_LATCH;
        end else if (split_sectors) begin
          state_next = S_MUL0;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LATCH: state_next = split_sectors ? S_MUL0 : S_DONE;
      S_MUL0:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_DONE;
      S_DONE:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pend             <= 1'b0;
      low_sector_count <= '0;
    end else begin
      state <= state_next;
      pend  <= (state == S_SCAN) & bit_set;
      if (state == S_LATCH) begin
        low_sector_count <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_sh  <= word_ch.spin_word;
      first    <= word_ch.first_of_batch;
      bit_pos  <= '0;
      cnt_low  <= '0;
      cnt_high <= '0;
      cnt_all  <= '0;
      acc_low  <= '0;
      acc_high <= '0;
    end else begin
      if (state == S_SCAN) begin
        word_sh   <= word_sh >> 1;
        bit_pos   <= SHIFT_W'(bit_pos + SHIFT_W'(1));
        pend_high <= hi_sel;
        if (bit_set) begin
          cnt_all <= IDX_W'(cnt_all + IDX_W'(1));
          if (is_low) begin
            cnt_low <= IDX_W'(cnt_low + IDX_W'(1));
          end else begin
            cnt_high <= IDX_W'(cnt_high + IDX_W'(1));
          end
        end
      end
      if (pend) begin
        if (pend_high) begin
          acc_high <= acc_high + rdata;
        end else begin
          acc_low <= acc_low + rdata;
        end
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL0: begin
        mul_a = acc_high[WORD_W/2-1:0];
        mul_b = low_sector_count[WORD_W/2-1:0];
      end
      S_MUL1: begin
        mul_a = acc_high[WORD_W/2-1:0];
        mul_b = low_sector_count[WORD_W-1:WORD_W/2];
      end
      S_MUL2: begin
        mul_a = acc_high[WORD_W-1:WORD_W/2];
        mul_b = low_sector_count[WORD_W/2-1:0];
      end
      default: begin
      end
    endcase
  end

  assign mul_full = WORD_W'(mul_a) * WORD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (state == S_MUL0) begin
      prod <= mul_full;
    end else if (state == S_MUL1 || state == S_MUL2) begin
      prod <= prod + {mul_full[WORD_W/2-1:0], {(WORD_W/2){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rank_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= split_sectors ? (prod + acc_low) : acc_low;
    end
  end

  assign word_ch.ready       = (state == S_IDLE) & fill_done;
  assign rank_ch.valid       = out_valid;
  assign rank_ch.state_index = out_data;

endmodule

[test/tb.sv]
module tb;
  import csr_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [WORD_W-1:0] spin;
    logic              first;
  } word_item_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  csr_in_if  word_ch();
  csr_out_if rank_ch();

  combinadic_state_rank_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .word_ch   (word_ch),
    .rank_ch   (rank_ch)
  );

  logic [WORD_W-1:0] pascal [0:TABLE_DIM-1][0:TABLE_DIM-1];
  logic [WORD_W-1:0] low_count;
  logic [SECTOR_W-1:0] sec_bits;
  logic              split_on;

  word_item_t        pend_words[$];
  logic [WORD_W-1:0] rank_due[$];
  word_item_t        next_word;
  logic [WORD_W-1:0] want;
  logic              in_taken;
  logic              calm;
  int                quiet_cycles;
  int                mismatches;

  function automatic logic [WORD_W-1:0] binom(int unsigned n, int unsigned k);
    if (k > n || n >= TABLE_DIM || k >= TABLE_DIM) return '0;
    return pascal[n][k];
  endfunction

  function automatic logic [WORD_W-1:0] combinadic(logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] acc;
    int unsigned       k;
    acc = '0;
    k = 1;
    for (int c = 0; c < WORD_W; c++) begin
      if (w[c]) begin
        acc += binom(c, k);
        k++;
      end
    end
    return acc;
  endfunction

  function automatic logic [WORD_W-1:0] rank_spin_word(logic [WORD_W-1:0] w, logic first);
    int unsigned       nb;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
    nb = (sec_bits >= WORD_W) ? WORD_W : sec_bits;
    mask = (nb >= WORD_W) ? '1 : ((64'd1 << nb) - 64'd1);
    low = w & mask;
    high = (nb >= WORD_W) ? '0 : (w >> nb);
    if (first) low_count = binom(nb, $countones(low));
    if (split_on) return combinadic(high) * low_count + combinadic(low);
    return combinadic(w);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    w = '0;
    case ($urandom_range(0, 5))
      0, 1: w = {$urandom, $urandom};
      2: begin
        repeat ($urandom_range(1, 4)) w[$urandom_range(0, WORD_W - 1)] = 1'b1;
      end
      3: begin
        repeat ($urandom_range(1, 4)) w[$urandom_range(0, WORD_W - 1)] = 1'b1;
        w = ~w;
      end
      4: w = {$urandom, $urandom} >> $urandom_range(0, WORD_W - 1);
      default: w = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return w;
  endfunction

  task automatic queue_word(logic [WORD_W-1:0] w, logic first);
    pend_words.push_back('{spin: w, first: first});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pend_words.size() != 0 || word_ch.valid || rank_due.size() != 0) @(posedge clk);
  endtask

  // The block is idle once every result is back; the extra cycles cover its tail.
  task automatic settle_then_set(int sec, logic spl);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SECTOR_BITS, CFG_W'(sec));
    write_reg(REG_SPLIT_SECTORS, CFG_W'(spl));
    sec_bits = SECTOR_W'(sec);
    split_on = spl;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        in_taken = 1'b1;
        rank_due.push_back(rank_spin_word(word_ch.spin_word, word_ch.first_of_batch));
      end
      if (rank_ch.valid && rank_ch.ready) begin
        if (rank_due.size() == 0) begin
          $error("state_index: expected nothing, actual %h", rank_ch.state_index);
          mismatches++;
        end else begin
          want = rank_due.pop_front();
          if (rank_ch.state_index !== want) begin
            $error("state_index: expected %h, actual %h", want, rank_ch.state_index);
            mismatches++;
          end
        end
      end
      if (in_taken || (rank_ch.valid && rank_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      word_ch.valid <= 1'b0;
    end else if (!word_ch.valid || in_taken) begin
      if (pend_words.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
        next_word = pend_words.pop_front();
        word_ch.valid <= 1'b1;
        word_ch.spin_word <= next_word.spin;
        word_ch.first_of_batch <= next_word.first;
      end else begin
        word_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rank_ch.ready <= 1'b0;
    end else begin
      rank_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  initial begin
    int   corner [6];
    int   sec;
    int   run;
    logic first;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    word_ch.valid = 1'b0;
    word_ch.spin_word = '0;
    word_ch.first_of_batch = 1'b0;
    rank_ch.ready = 1'b0;
    in_taken = 1'b0;
    calm = 1'b0;
    quiet_cycles = 0;
    mismatches = 0;
    low_count = '0;
    sec_bits = SECTOR_W'(64);
    split_on = 1'b0;
    corner = '{64, 0, 1, 63, 127, 32};
    for (int n = 0; n < TABLE_DIM; n++) begin
      for (int k = 0; k < TABLE_DIM; k++) pascal[n][k] = '0;
      pascal[n][0] = 64'd1;
      for (int k = 1; k <= n; k++) pascal[n][k] = pascal[n-1][k-1] + pascal[n-1][k];
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_word(64'h0, 1'b0);
    queue_word('1, 1'b0);
    queue_word(64'h1, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 1'b0);
    queue_word(64'h5555_5555_5555_5555, 1'b0);
    queue_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

    // Split mode before any batch start: the high sector contributes nothing.
    settle_then_set(32, 1'b1);
    queue_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_word(64'h0000_0005_0000_0001, 1'b0);
    queue_word(64'h0000_0003_0000_0007, 1'b1);
    queue_word(64'h0000_0006_0000_000B, 1'b0);
    queue_word('1, 1'b1);

    settle_then_set(0, 1'b1);
    queue_word(64'h1234_5678_9ABC_DEF0, 1'b1);
    queue_word('1, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 1'b0);

    settle_then_set(127, 1'b1);
    queue_word('1, 1'b1);
    queue_word(64'hF0F0_0F0F_3C3C_C3C3, 1'b0);

    settle_then_set(1, 1'b1);
    queue_word(64'h1, 1'b1);
    queue_word(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    queue_word(64'h2, 1'b0);

    // The batch count is latched in plain mode too and then used in split mode.
    settle_then_set(60, 1'b0);
    queue_word(64'h0FFF_0000_0000_00F0, 1'b1);
    settle_then_set(60, 1'b1);
    queue_word(64'hA000_0000_0000_0003, 1'b0);

    for (int p = 0; p < 12; p++) begin
      sec = (p < 6) ? corner[p] : $urandom_range(0, 127);
      settle_then_set(sec, (p % 4) != 3);
      calm = (p == 5);
      run = 0;
      for (int i = 0; i < 78; i++) begin
        if (run == 0) begin
          run = $urandom_range(1, 12);
          first = 1'b1;
        end else begin
          first = ($urandom_range(0, 19) == 0);
        end
        run--;
        queue_word(pick_word(), first);
        if (p == 8 && i == 39) drain();
      end
    end

    drain();
    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && rank_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/csr_pkg.sv
hw/rtl/csr_if.sv
hw/rtl/csr_binom_table.sv
hw/rtl/combinadic_state_rank_unit.sv
test/tb.sv
